// File: rtl/core/acs_pkg.sv
// shared types, codes and constants of the annealing cooling schedule
package acs_pkg;

	// default widths of the iteration counter and of the temperature range
	localparam int ITER_BITS_DEF = 32;
	localparam int TEMP_BITS_DEF = 32;

	// configuration register file
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_T_INIT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_EXP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_BLOCK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 2'd3;

	// unsigned Q2.30 arithmetic
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [31:0] Q30_MAX = 32'hFFFF_FFFF;

	// register reset values
	localparam logic [31:0] T_INIT_RST = 32'd65536;
	localparam logic [31:0] RATIO_RST  = Q30_ONE;
	localparam logic [31:0] STEP_RST   = 32'd1;

	// request modes
	localparam logic [1:0] MODE_EVAL  = 2'd0;
	localparam logic [1:0] MODE_COUNT = 2'd1;
	localparam logic [1:0] MODE_LOAD  = 2'd2;

	// schedule kinds
	localparam logic KIND_EXP   = 1'b0;
	localparam logic KIND_BLOCK = 1'b1;

	// operand pairs of the shared multiplier
	localparam logic [1:0] MUL_ACC = 2'd0; // acc * base
	localparam logic [1:0] MUL_SQ  = 2'd1; // base * base
	localparam logic [1:0] MUL_FIN = 2'd2; // t_init * acc

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       div_step;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       acc_wb;
		logic       base_wb;
		logic       k_shift;
		logic       fin_wb;
		logic       out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic       kind;
		logic       div_last;
		logic       k_zero;
		logic       k_lsb;
		logic       k_one;
	} sts_t;

endpackage

// File: rtl/core/annealing_cooling_schedule.sv
// top level of the annealing cooling schedule: controller and datapath
//
// Gives one temperature T = t_init * r^k per request beat, in unsigned Q16.16,
// with r^k formed by right-to-left square-and-multiply in unsigned Q2.30 (each
// product truncated and saturated) and T saturated at 2^TEMP_BITS - 1. The
// per-iteration kind uses k = iteration and ratio_exp; the per-block kind uses
// k = iteration / step_length (a step length of zero counts as one) and
// ratio_block. Mode 0 evaluates at the given iteration, mode 1 at the internal
// counter and then advances it with wrap at ITER_BITS, mode 2 loads the counter
// and returns a zero temperature; the unused mode returns all zeros. One item
// is worked on at a time. A load or the unused mode goes from dispatch straight
// to the result. An evaluation first runs, in the per-block kind, the bit-serial
// divider over all ITER_BITS bits of the dividend, then works through k from its
// lowest bit: a set bit multiplies acc by base, and every bit below the highest
// set bit then squares base, each product passing through the one shared 32x32
// multiplier with a registered product before it is written back; last comes
// t_init * acc. A finished result waits in the output register, and the next
// request beat is taken while it waits; a second finished result waits until
// the first has left.
// Configuration writes must happen while no item is in flight.
module annealing_cooling_schedule #(
	parameter int ITER_BITS = acs_pkg::ITER_BITS_DEF,
	parameter int TEMP_BITS = acs_pkg::TEMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic                          schedule_kind,
	input  logic [31:0]                   iteration,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   temperature,
	output logic [31:0]                   used_iteration,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acs_pkg::CFG_W-1:0]     cfg_data
);
	import acs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// state machine: dispatch, divide, square-and-multiply rounds, result
	acs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// registers, counter, divider and the shared multiplier
	acs_dp #(
		.ITER_BITS (ITER_BITS),
		.TEMP_BITS (TEMP_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.schedule_kind  (schedule_kind),
		.iteration      (iteration),
		.temperature    (temperature),
		.used_iteration (used_iteration)
	);

endmodule

// File: rtl/core/acs_ctrl.sv
// sequencing controller of the annealing cooling schedule
module acs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  acs_pkg::sts_t sts,
	output acs_pkg::cmd_t cmd
);
	import acs_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_DIV    = 4'd2;
	localparam logic [3:0] S_POW    = 4'd3;
	localparam logic [3:0] S_ACC_WB = 4'd4;
	localparam logic [3:0] S_SQ     = 4'd5;
	localparam logic [3:0] S_SQ_WB  = 4'd6;
	localparam logic [3:0] S_FIN_WB = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_DISP: begin
				if ((sts.mode == MODE_EVAL) || (sts.mode == MODE_COUNT)) begin
					state_d = (sts.kind == KIND_BLOCK) ? S_DIV : S_POW;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_POW;
				end
			end
			S_POW: begin
				if (sts.k_zero) begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_FIN;
					state_d     = S_FIN_WB;
				end else if (sts.k_lsb) begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_ACC;
					state_d     = S_ACC_WB;
				end else begin
					state_d = S_SQ;
				end
			end
			S_ACC_WB: begin
				cmd.acc_wb  = 1'b1;
				cmd.k_shift = 1'b1;
				if (sts.k_one) begin
					// last bit used, base no longer needed
					state_d = S_POW;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_SQ;
					state_d     = S_SQ_WB;
				end
			end
			S_SQ: begin
				cmd.k_shift = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQ;
				state_d     = S_SQ_WB;
			end
			S_SQ_WB: begin
				cmd.base_wb = 1'b1;
				state_d     = S_POW;
			end
			S_FIN_WB: begin
				cmd.fin_wb = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/acs_dp.sv
// datapath of the annealing cooling schedule: registers, divider, shared multiplier
module acs_dp #(
	parameter int ITER_BITS = acs_pkg::ITER_BITS_DEF,
	parameter int TEMP_BITS = acs_pkg::TEMP_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  acs_pkg::cmd_t                  cmd,
	output acs_pkg::sts_t                  sts,
	input  logic                           cfg_we,
	input  logic [acs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acs_pkg::CFG_W-1:0]      cfg_data,
	input  logic [1:0]                     mode,
	input  logic                           schedule_kind,
	input  logic [31:0]                    iteration,
	output logic [31:0]                    temperature,
	output logic [31:0]                    used_iteration
);
	import acs_pkg::*;

	localparam int DivCntW = $clog2(ITER_BITS);
	localparam logic [DivCntW-1:0] DivLast = DivCntW'(ITER_BITS - 1);
	localparam logic [33:0] TempMax =
		(TEMP_BITS >= 34) ? '1 : ((34'd1 << TEMP_BITS) - 34'd1);

	// configuration
	logic [31:0] t_init_q;
	logic [31:0] ratio_exp_q;
	logic [31:0] ratio_block_q;
	logic [31:0] step_length_q;
	logic [ITER_BITS-1:0] counter_q;

	// item in flight
	logic [1:0]           mode_q;
	logic                 kind_q;
	logic [ITER_BITS-1:0] k_q;
	logic [ITER_BITS-1:0] used_q;
	logic [31:0]          rem_q;
	logic [DivCntW-1:0]   div_cnt_q;
	logic [31:0]          acc_q;
	logic [31:0]          base_q;
	logic [63:0]          prod_q;
	logic [31:0]          res_temp_q;
	logic [31:0]          temperature_q;
	logic [31:0]          used_out_q;

	logic [ITER_BITS-1:0] iter_m;
	logic [31:0]          len_eff;
	logic [32:0]          rem_shift;
	logic                 q_bit;
	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [33:0]          prod_hi;
	logic [31:0]          q30_sat;
	logic [33:0]          temp_sat;

	assign iter_m  = ITER_BITS'(iteration);
	assign len_eff = (step_length_q == 32'd0) ? 32'd1 : step_length_q;

	// restoring divider, one quotient bit per step
	assign rem_shift = {rem_q, k_q[ITER_BITS-1]};
	assign q_bit     = (rem_shift >= {1'b0, len_eff});

	always_comb begin
		case (cmd.mul_sel)
			MUL_ACC: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			MUL_SQ: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			MUL_FIN: begin
				mul_a = t_init_q;
				mul_b = acc_q;
			end
			default: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
		endcase
	end

	assign prod_hi  = prod_q[63:30];
	assign q30_sat  = (prod_hi[33:32] != 2'b00) ? Q30_MAX : prod_hi[31:0];
	assign temp_sat = (prod_hi > TempMax) ? TempMax : prod_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_init_q      <= T_INIT_RST;
			ratio_exp_q   <= RATIO_RST;
			ratio_block_q <= RATIO_RST;
			step_length_q <= STEP_RST;
			counter_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_T_INIT:      t_init_q      <= cfg_data;
					REG_RATIO_EXP:   ratio_exp_q   <= cfg_data;
					REG_RATIO_BLOCK: ratio_block_q <= cfg_data;
					REG_STEP_LENGTH: step_length_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				if (mode == MODE_COUNT) begin
					counter_q <= counter_q + ITER_BITS'(1);
				end else if (mode == MODE_LOAD) begin
					counter_q <= iter_m;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q     <= mode;
			kind_q     <= schedule_kind;
			rem_q      <= '0;
			div_cnt_q  <= '0;
			acc_q      <= Q30_ONE;
			base_q     <= (schedule_kind == KIND_BLOCK) ? ratio_block_q : ratio_exp_q;
			res_temp_q <= '0;
			case (mode)
				MODE_EVAL: begin
					k_q    <= iter_m;
					used_q <= iter_m;
				end
				MODE_COUNT: begin
					k_q    <= counter_q;
					used_q <= counter_q;
				end
				MODE_LOAD: begin
					k_q    <= '0;
					used_q <= iter_m;
				end
				default: begin
					k_q    <= '0;
					used_q <= '0;
				end
			endcase
		end
		if (cmd.div_step) begin
			rem_q     <= q_bit ? 32'(rem_shift - {1'b0, len_eff}) : rem_shift[31:0];
			k_q       <= {k_q[ITER_BITS-2:0], q_bit};
			div_cnt_q <= div_cnt_q + DivCntW'(1);
		end
		if (cmd.k_shift) begin
			k_q <= k_q >> 1;
		end
		if (cmd.mul_en) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
		if (cmd.acc_wb) begin
			acc_q <= q30_sat;
		end
		if (cmd.base_wb) begin
			base_q <= q30_sat;
		end
		if (cmd.fin_wb) begin
			res_temp_q <= temp_sat[31:0];
		end
		if (cmd.out_load) begin
			temperature_q <= res_temp_q;
			used_out_q    <= 32'(used_q);
		end
	end

	assign sts.mode     = mode_q;
	assign sts.kind     = kind_q;
	assign sts.div_last = (div_cnt_q == DivLast);
	assign sts.k_zero   = (k_q == '0);
	assign sts.k_lsb    = k_q[0];
	assign sts.k_one    = (k_q == ITER_BITS'(1));

	assign temperature    = temperature_q;
	assign used_iteration = used_out_q;

endmodule

// File: rtl/core/acs_checker.sv
// port-level checks of the annealing cooling schedule, bound to the top level
module acs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] temperature,
	input logic [31:0] used_iteration
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(temperature) && $stable(used_iteration))
		else $error("result payload changed while stalled");

	// one item at a time: after a request beat the block is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous item still in flight");

	// a new result appears only as the block frees up for the next request
	a_result_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result shown while item still in flight");

endmodule

bind annealing_cooling_schedule acs_checker u_acs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.temperature    (temperature),
	.used_iteration (used_iteration)
);
